// ----- rtl/kne_pkg.sv -----
// ----------------------------------------------------------------------------
// kne_pkg
// Shared types, constants and the fixed per-key descriptor table of the
// session key negotiation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kne_pkg;

    localparam int KEY_COUNT    = 23;
    localparam int DEFINED_KEYS = 23;
    localparam int KEY_W        = 5;
    localparam int ADDR_W       = $clog2(KEY_COUNT);
    localparam int VAL_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int KIND_W       = 3;

    localparam logic [OP_W-1:0] OP_CHECK   = 2'd0;
    localparam logic [OP_W-1:0] OP_NEGOT   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY = 2'd2;

    localparam logic [KIND_W-1:0] KIND_OR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AND  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MIN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MAX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MINZ = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DIG  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_MARK = 3'd6;

    localparam logic [VAL_W-1:0] DIG_NONE = 32'd1;
    localparam logic [VAL_W-1:0] DIG_CRC  = 32'd2;

    localparam logic [VAL_W-1:0] V_SEG_MAX  = 32'd16777215;
    localparam logic [VAL_W-1:0] V_CNT_MAX  = 32'd65535;
    localparam logic [VAL_W-1:0] V_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] V_BURST    = 32'd262144;
    localparam logic [VAL_W-1:0] V_FBURST   = 32'd65536;
    localparam logic [VAL_W-1:0] V_SEG_DEF  = 32'd8192;
    localparam logic [VAL_W-1:0] V_TIME_MAX = 32'd3600;
    localparam logic [VAL_W-1:0] V_MARK_DEF = 32'd2048;
    localparam logic [VAL_W-1:0] V_SEG_MIN  = 32'd512;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  def;
        logic [VAL_W-1:0]  lo;
        logic [VAL_W-1:0]  hi;
    } key_desc_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             key_ok;
        key_desc_t        desc;
        logic [VAL_W-1:0] stored;
        logic [VAL_W-1:0] offered;
        logic             done;
    } alu_req_t;

    typedef struct packed {
        logic [VAL_W-1:0]    result_value;
        logic [STATUS_W-1:0] status;
        logic                write;
    } alu_res_t;

    function automatic key_desc_t mk_desc(input logic [KIND_W-1:0] kind,
                                          input logic [VAL_W-1:0] def,
                                          input logic [VAL_W-1:0] lo,
                                          input logic [VAL_W-1:0] hi);
        key_desc_t d;
        d.kind = kind;
        d.def  = def;
        d.lo   = lo;
        d.hi   = hi;
        return d;
    endfunction

    function automatic key_desc_t key_desc(input logic [KEY_W-1:0] k);
        key_desc_t d;
        case (k)
            5'd0:    d = mk_desc(KIND_OR,   32'd1,     32'd0,     32'd1);
            5'd1:    d = mk_desc(KIND_AND,  32'd1,     32'd0,     32'd1);
            5'd2:    d = mk_desc(KIND_MIN,  32'd1,     32'd1,     V_CNT_MAX);
            5'd3:    d = mk_desc(KIND_MIN,  V_SEG_DEF, V_SEG_MIN, V_SEG_MAX);
            5'd4:    d = mk_desc(KIND_MIN,  V_SEG_DEF, V_SEG_MIN, V_SEG_MAX);
            5'd5:    d = mk_desc(KIND_MIN,  V_BURST,   V_SEG_MIN, V_SEG_MAX);
            5'd6:    d = mk_desc(KIND_MIN,  V_FBURST,  V_SEG_MIN, V_SEG_MAX);
            5'd7:    d = mk_desc(KIND_MAX,  32'd2,     32'd0,     V_TIME_MAX);
            5'd8:    d = mk_desc(KIND_MIN,  32'd20,    32'd0,     V_TIME_MAX);
            5'd9:    d = mk_desc(KIND_MIN,  32'd1,     32'd1,     V_CNT_MAX);
            5'd10:   d = mk_desc(KIND_OR,   32'd1,     32'd0,     32'd1);
            5'd11:   d = mk_desc(KIND_OR,   32'd1,     32'd0,     32'd1);
            5'd12:   d = mk_desc(KIND_MIN,  32'd0,     32'd0,     32'd2);
            5'd13:   d = mk_desc(KIND_DIG,  32'd1,     32'd1,     32'd3);
            5'd14:   d = mk_desc(KIND_DIG,  32'd1,     32'd1,     32'd3);
            5'd15:   d = mk_desc(KIND_AND,  32'd0,     32'd0,     32'd1);
            5'd16:   d = mk_desc(KIND_AND,  32'd0,     32'd0,     32'd1);
            5'd17:   d = mk_desc(KIND_MARK, V_MARK_DEF, 32'd1,    V_CNT_MAX);
            5'd18:   d = mk_desc(KIND_MARK, V_MARK_DEF, 32'd1,    V_CNT_MAX);
            5'd19:   d = mk_desc(KIND_AND,  32'd0,     32'd0,     32'd1);
            5'd20:   d = mk_desc(KIND_MIN,  V_SEG_DEF, V_SEG_MIN, V_SEG_MAX);
            5'd21:   d = mk_desc(KIND_MIN,  V_SEG_DEF, V_SEG_MIN, V_SEG_MAX);
            5'd22:   d = mk_desc(KIND_MINZ, 32'd0,     32'd2,     V_ALL_ONES);
            default: d = mk_desc(KIND_OR,   32'd0,     32'd0,     32'd0);
        endcase
        return d;
    endfunction

    function automatic logic key_ok(input logic [KEY_W-1:0] k);
        logic [KEY_W:0] kx;
        kx = {1'b0, k};
        return (kx < (KEY_W+1)'(KEY_COUNT)) && (kx < (KEY_W+1)'(DEFINED_KEYS));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kne_if.sv -----
// ----------------------------------------------------------------------------
// kne_if
// Valid/ready channels of the key negotiation engine: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface kne_req_if
    import kne_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_index;
    logic [VAL_W-1:0] offered_value;
    logic             companion_done;

    modport source (output valid, output op, output key_index,
                    output offered_value, output companion_done, input ready);
    modport sink   (input valid, input op, input key_index,
                    input offered_value, input companion_done, output ready);
endinterface

interface kne_rsp_if
    import kne_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    result_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/kne_ram.sv -----
// ----------------------------------------------------------------------------
// kne_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kne_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/kne_alu.sv -----
// ----------------------------------------------------------------------------
// kne_alu
// Range check, combine rules, restore to default and plain write for one
// key: clamps, min/max, OR/AND, digest intersection and marker rule.
// ----------------------------------------------------------------------------
`default_nettype none

module kne_alu
    import kne_pkg::*;
(
    input  wire alu_req_t req,
    output      alu_res_t res
);

    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] s;
    logic             out_rng;
    logic [VAL_W-1:0] comb_val;
    logic [VAL_W-1:0] chk_val;
    logic             chk_bad;

    assign v = req.offered;
    assign s = req.stored;
    assign out_rng = (v < req.desc.lo) || (v > req.desc.hi);

    always_comb
    begin
        case (req.desc.kind)
            KIND_OR:   comb_val = v | s;
            KIND_AND:  comb_val = v & s;
            KIND_MIN:  comb_val = (v > s) ? s : v;
            KIND_MAX:  comb_val = (s > v) ? s : v;
            KIND_MINZ: comb_val = ((v > s) || (v == '0)) ? s : v;
            KIND_DIG:  comb_val = (v[1] && s[1]) ? DIG_CRC : DIG_NONE;
            default:   comb_val = req.done ? '0 : VAL_W'(1);
        endcase
    end

    always_comb
    begin
        chk_val = v;
        chk_bad = 1'b0;
        case (req.desc.kind)
            KIND_MIN:
            begin
                if (out_rng)
                begin
                    chk_val = req.desc.lo;
                    chk_bad = 1'b1;
                end
            end
            KIND_MAX:
            begin
                if (out_rng)
                begin
                    chk_val = req.desc.hi;
                    chk_bad = 1'b1;
                end
            end
            KIND_MINZ:
            begin
                if (out_rng && (v != '0))
                begin
                    chk_val = req.desc.lo;
                    chk_bad = 1'b1;
                end
            end
            default:
            begin
                chk_val = v;
                chk_bad = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.result_value = '0;
        res.status       = ST_BAD_KEY;
        res.write        = 1'b0;
        if (req.key_ok)
        begin
            res.status = ST_OK;
            case (req.op)
                OP_CHECK:
                begin
                    res.result_value = chk_val;
                    res.status       = chk_bad ? ST_CLAMPED : ST_OK;
                end
                OP_NEGOT:
                begin
                    res.result_value = comb_val;
                    res.write        = 1'b1;
                end
                OP_RESTORE:
                begin
                    res.result_value = req.desc.def;
                    res.write        = 1'b1;
                end
                default:
                begin
                    res.result_value = v;
                    res.write        = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/iscsi_key_negotiation_engine_core.sv -----
// ----------------------------------------------------------------------------
// iscsi_key_negotiation_engine_core
// Session key table with check, negotiate, restore and write operations.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | op, key_index, offered_value, companion_done
//  rsp     | out | result_value, status
//
//  Each item runs a table read (registered RAM read), then combine,
//  write back and load of the response register.
//  Reset marks every entry as unwritten; an unwritten entry reads as its
//  key default, so no clearing pass is needed.
//  A held response stalls the combine cycle; the next item is accepted
//  while a finished response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module iscsi_key_negotiation_engine_core
    import kne_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    kne_req_if.sink  req,
    kne_rsp_if.source rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                st_reg;
    logic                st_next;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic                done_reg;
    logic [KEY_COUNT-1:0] vld_reg;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    result_reg;
    logic [STATUS_W-1:0] status_reg;

    logic             accept;
    logic             cur_ok;
    logic             entry_vld;
    logic             out_free;
    logic             fin;
    logic             ram_we;
    logic             ram_re;
    logic [VAL_W-1:0] ram_rdata;
    key_desc_t        desc;
    alu_req_t         alu_req;
    alu_res_t         alu_res;

    assign req.ready = (st_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign ram_re    = accept && key_ok(req.key_index);

    assign cur_ok    = key_ok(key_reg);
    assign desc      = key_desc(key_reg);
    assign entry_vld = cur_ok ? vld_reg[key_reg[ADDR_W-1:0]] : 1'b0;

    assign alu_req.op      = op_reg;
    assign alu_req.key_ok  = cur_ok;
    assign alu_req.desc    = desc;
    assign alu_req.stored  = entry_vld ? ram_rdata : desc.def;
    assign alu_req.offered = val_reg;
    assign alu_req.done    = done_reg;

    assign out_free = !out_valid_reg || rsp.ready;
    assign fin      = (st_reg == S_EXEC) && out_free;
    assign ram_we   = fin && alu_res.write;

    kne_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    kne_ram #(
        .WIDTH (VAL_W),
        .DEPTH (KEY_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (key_reg[ADDR_W-1:0]),
        .wdata (alu_res.result_value),
        .re    (ram_re),
        .raddr (req.key_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (ram_we)
            begin
                vld_reg[key_reg[ADDR_W-1:0]] <= 1'b1;
            end
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            key_reg  <= req.key_index;
            val_reg  <= req.offered_value;
            done_reg <= req.companion_done;
        end
        if (fin)
        begin
            result_reg <= alu_res.result_value;
            status_reg <= alu_res.status;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = result_reg;
    assign rsp.status       = status_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (st_reg == S_EXEC))
        else $error("accepted item did not start execution");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EXEC) && out_valid_reg && !rsp.ready |=> (st_reg == S_EXEC))
        else $error("execution finished while response register was full");

    a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> fin && cur_ok)
        else $error("table written outside a finishing valid-key item");

    a_bad_key_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        fin && !cur_ok |=> out_valid_reg && (status_reg == ST_BAD_KEY)
                           && (result_reg == '0))
        else $error("invalid key did not return the error response");

    a_finish_fills: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> out_valid_reg && (st_reg == S_IDLE))
        else $error("finished item did not load the response register");
`endif

endmodule

`default_nettype wire
